FILE: hdl/ddcp_pkg.sv
// Shared widths, reset values, codes and types of the cascaded PID block.
package ddcp_pkg;

  localparam int unsigned ErrW    = 12;
  localparam int unsigned EncW    = 16;
  localparam int unsigned PwmW    = 13;
  localparam int unsigned GainW   = 16;
  localparam int unsigned BaseW   = 10;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned OffW    = 30;  // direction offset, Q.12 sum truncated
  localparam int unsigned AddrW   = 5;   // eight 32-bit registers
  localparam int unsigned DataW   = 32;
  localparam int unsigned FracBits = 12;

  localparam logic [PwmW-1:0] PwmMax = 13'd7100;

  localparam logic [GainW-1:0] RstDirKp   = 16'd369;
  localparam logic [GainW-1:0] RstDirKd   = 16'd819;
  localparam logic [GainW-1:0] RstSpeedKp = 16'd30720;
  localparam logic [GainW-1:0] RstSpeedKi = 16'd1434;
  localparam logic [BaseW-1:0] RstBase    = 10'd120;
  localparam logic [PwmW-1:0]  RstMinR    = 13'd1500;
  localparam logic [PwmW-1:0]  RstMinL    = 13'd1000;
  localparam logic [ModeW-1:0] RstMode    = 2'd0;

  localparam int unsigned ModeSquareBit = 0;
  localparam int unsigned ModeCumulBit  = 1;

  typedef enum logic [2:0] {
    REG_DIR_KP   = 3'd0,
    REG_DIR_KD   = 3'd1,
    REG_SPEED_KP = 3'd2,
    REG_SPEED_KI = 3'd3,
    REG_BASE     = 3'd4,
    REG_MIN_R    = 3'd5,
    REG_MIN_L    = 3'd6,
    REG_MODE     = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic [GainW-1:0] kp;
    logic [GainW-1:0] kd;
    logic             square;
  } dir_cfg_t;

  typedef struct packed {
    logic [GainW-1:0] kp;
    logic [GainW-1:0] ki;
    logic [BaseW-1:0] base_speed;
    logic [PwmW-1:0]  pwm_min;
    logic             cumulative;
  } lane_cfg_t;

endpackage

FILE: hdl/ddcp_in_if.sv
// Input channel: one control tick per beat.
interface ddcp_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [ddcp_pkg::ErrW-1:0]   line_error;
  logic signed [ddcp_pkg::EncW-1:0]   encoder_right;
  logic signed [ddcp_pkg::EncW-1:0]   encoder_left;

  modport source (output valid, line_error, encoder_right, encoder_left, input ready);
  modport sink   (input valid, line_error, encoder_right, encoder_left, output ready);
endinterface

FILE: hdl/ddcp_out_if.sv
// Output channel: both wheel PWM compare values per beat.
interface ddcp_out_if;
  logic                        valid;
  logic                        ready;
  logic [ddcp_pkg::PwmW-1:0]   pwm_right;
  logic [ddcp_pkg::PwmW-1:0]   pwm_left;

  modport source (output valid, pwm_right, pwm_left, input ready);
  modport sink   (input valid, pwm_right, pwm_left, output ready);
endinterface

FILE: hdl/ddcp_dir.sv
// Direction PD: optional square, two gain products, sum, truncate to steering offset.
module ddcp_dir (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [ddcp_pkg::ErrW-1:0]   line_error_i,
  input  ddcp_pkg::dir_cfg_t                 cfg_i,
  output logic                               done_o,
  output logic signed [ddcp_pkg::OffW-1:0]   offset_o
);

  logic [3:0]                            v_q;
  logic signed [ddcp_pkg::ErrW-1:0]      prev_q;
  logic signed [ddcp_pkg::ErrW-1:0]      e_q;
  logic signed [ddcp_pkg::ErrW:0]        diff_q;
  logic signed [2*ddcp_pkg::ErrW-1:0]    sq_q;
  logic signed [2*ddcp_pkg::ErrW-1:0]    sq;
  logic signed [2*ddcp_pkg::ErrW-1:0]    term;
  logic signed [40:0]                    pa_q;
  logic signed [29:0]                    pb_q;
  logic signed [41:0]                    sum_q;
  logic signed [41:0]                    shr;
  logic signed [41:0]                    quo;
  logic signed [ddcp_pkg::OffW-1:0]      offset_q;

  assign sq = (2*ddcp_pkg::ErrW)'(line_error_i) * (2*ddcp_pkg::ErrW)'(line_error_i);

  always_comb begin
    if (cfg_i.square) begin
      term = (e_q < 0) ? -sq_q : sq_q;
    end else begin
      term = (2*ddcp_pkg::ErrW)'(e_q);
    end
  end

  // toward-zero truncation of the Q.12 sum
  assign shr = sum_q >>> ddcp_pkg::FracBits;
  assign quo = (sum_q[41] && (sum_q[ddcp_pkg::FracBits-1:0] != '0)) ? shr + 42'sd1 : shr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      prev_q <= '0;
    end else begin
      v_q <= {v_q[2:0], start_i};
      if (start_i) begin
        prev_q <= line_error_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      e_q    <= line_error_i;
      sq_q   <= sq;
      diff_q <= (ddcp_pkg::ErrW+1)'(line_error_i) - (ddcp_pkg::ErrW+1)'(prev_q);
    end
    if (v_q[0]) begin
      pa_q <= 41'($signed({1'b0, cfg_i.kp})) * 41'(term);
      pb_q <= 30'($signed({1'b0, cfg_i.kd})) * 30'(diff_q);
    end
    if (v_q[1]) begin
      sum_q <= 42'(pa_q) + 42'(pb_q);
    end
    if (v_q[2]) begin
      offset_q <= quo[ddcp_pkg::OffW-1:0];
    end
  end

  assign done_o   = v_q[3];
  assign offset_o = offset_q;

endmodule

FILE: hdl/ddcp_lane.sv
// One wheel lane: target update, PI speed loop, accumulator and PWM clamp.
module ddcp_lane (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic                               subtract_i,
  input  logic signed [ddcp_pkg::OffW-1:0]   offset_i,
  input  logic signed [ddcp_pkg::EncW-1:0]   encoder_i,
  input  ddcp_pkg::lane_cfg_t                cfg_i,
  output logic                               done_o,
  output logic [ddcp_pkg::PwmW-1:0]          pwm_o
);

  logic [6:0]                 v_q;
  logic signed [15:0]         target_q;
  logic signed [31:0]         integ_q;
  logic signed [15:0]         acc_q;
  logic signed [16:0]         err_q;
  logic signed [33:0]         p1_q;
  logic signed [48:0]         p2_q;
  logic signed [49:0]         sum_q;
  logic signed [37:0]         pi_q;
  logic [ddcp_pkg::PwmW-1:0]  pwm_q;

  logic signed [31:0]         tgt_base;
  logic signed [31:0]         tgt_sum;
  logic signed [15:0]         target_d;
  logic signed [16:0]         err;
  logic signed [32:0]         isum;
  logic signed [31:0]         integ_d;
  logic signed [49:0]         shr;
  logic signed [49:0]         quo;
  logic signed [38:0]         asum;
  logic signed [15:0]         acc_d;
  logic [ddcp_pkg::PwmW-1:0]  lo;
  logic signed [15:0]         clamp;

  always_comb begin
    tgt_base = cfg_i.cumulative ? 32'(target_q) : $signed({22'b0, cfg_i.base_speed});
    tgt_sum  = subtract_i ? tgt_base - 32'(offset_i) : tgt_base + 32'(offset_i);
    if (tgt_sum > 32'sd32767) begin
      target_d = 16'sh7FFF;
    end else if (tgt_sum < -32'sd32768) begin
      target_d = 16'sh8000;
    end else begin
      target_d = tgt_sum[15:0];
    end

    err  = 17'(target_q) - 17'(encoder_i);
    isum = 33'(integ_q) + 33'(err);
    if (isum[32] != isum[31]) begin
      integ_d = isum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      integ_d = isum[31:0];
    end

    shr = sum_q >>> ddcp_pkg::FracBits;
    quo = (sum_q[49] && (sum_q[ddcp_pkg::FracBits-1:0] != '0)) ? shr + 50'sd1 : shr;

    asum = 39'(acc_q) + 39'(pi_q);
    if (asum > 39'sd32767) begin
      acc_d = 16'sh7FFF;
    end else if (asum < -39'sd32768) begin
      acc_d = 16'sh8000;
    end else begin
      acc_d = asum[15:0];
    end

    // a minimum above full scale acts as full scale
    lo    = (cfg_i.pwm_min > ddcp_pkg::PwmMax) ? ddcp_pkg::PwmMax : cfg_i.pwm_min;
    clamp = acc_q;
    if (clamp < $signed({3'b0, lo})) begin
      clamp = $signed({3'b0, lo});
    end
    if (clamp > $signed({3'b0, ddcp_pkg::PwmMax})) begin
      clamp = $signed({3'b0, ddcp_pkg::PwmMax});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q      <= '0;
      target_q <= $signed({6'b0, ddcp_pkg::RstBase});
      integ_q  <= '0;
      acc_q    <= '0;
    end else begin
      v_q <= {v_q[5:0], start_i};
      if (start_i) begin
        target_q <= target_d;
      end
      if (v_q[0]) begin
        integ_q <= integ_d;
      end
      if (v_q[4]) begin
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v_q[0]) begin
      err_q <= err;
    end
    if (v_q[1]) begin
      p1_q <= 34'($signed({1'b0, cfg_i.kp})) * 34'(err_q);
      p2_q <= 49'($signed({1'b0, cfg_i.ki})) * 49'(integ_q);
    end
    if (v_q[2]) begin
      sum_q <= 50'(p1_q) + 50'(p2_q);
    end
    if (v_q[3]) begin
      pi_q <= quo[37:0];
    end
    if (v_q[5]) begin
      pwm_q <= clamp[ddcp_pkg::PwmW-1:0];
    end
  end

  assign done_o = v_q[6];
  assign pwm_o  = pwm_q;

endmodule

FILE: hdl/differential_drive_cascaded_pid.sv
// Top level: register port, tick sequencer, direction PD, two wheel lanes and result register.
//
// Usage
//   in_if  : one beat per control tick (line_error, encoder_right, encoder_left).
//   out_if : one beat per tick carrying pwm_right and pwm_left, both 0..7100.
//   APB    : eight 32-bit registers at byte address 4*index, written in the
//            access phase; pready is tied high, reads return the register.
// Timing
//   One tick in flight at a time. Direction PD, then both wheel lanes side
//   by side, then the result register. in_if.ready returns once the result
//   register is loaded, so a new tick is taken only after the last one has
//   left the lanes.
// Stalls
//   The result register frees the input side: the next tick is accepted while
//   a result still waits. If a finished result meets a full result register,
//   the lanes hold it until out_if.ready drains the register.
// Reset
//   rst_ni clears the gains to their defaults, the targets to 120, the
//   integrals, accumulators and previous error to zero, and drops out_if.valid.
module differential_drive_cascaded_pid (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ddcp_pkg::AddrW-1:0]    paddr,
  input  logic [ddcp_pkg::DataW-1:0]    pwdata,
  output logic [ddcp_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  ddcp_in_if.sink                       in_if,
  ddcp_out_if.source                    out_if
);

  // configuration registers
  logic [ddcp_pkg::GainW-1:0] dir_kp_q, dir_kd_q, speed_kp_q, speed_ki_q;
  logic [ddcp_pkg::BaseW-1:0] base_q;
  logic [ddcp_pkg::PwmW-1:0]  min_r_q, min_l_q;
  logic [ddcp_pkg::ModeW-1:0] mode_q;

  ddcp_pkg::reg_idx_e         reg_idx;
  logic                       wr_en;

  // sequencer and result register
  ddcp_pkg::state_e           state_q, state_d;
  logic                       in_accept;
  logic                       out_free;
  logic                       load;
  logic                       out_valid_q;
  logic [ddcp_pkg::PwmW-1:0]  pwm_r_q, pwm_l_q;
  logic signed [ddcp_pkg::EncW-1:0] enc_r_q, enc_l_q;

  // datapath links
  ddcp_pkg::dir_cfg_t         dir_cfg;
  ddcp_pkg::lane_cfg_t        cfg_r, cfg_l;
  logic                       dir_done;
  logic signed [ddcp_pkg::OffW-1:0] offset;
  logic                       done_r, done_l;
  logic [ddcp_pkg::PwmW-1:0]  pwm_r, pwm_l;

  // ---------------------------------------------------------------- APB
  assign reg_idx = ddcp_pkg::reg_idx_e'(paddr[ddcp_pkg::AddrW-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_kp_q   <= ddcp_pkg::RstDirKp;
      dir_kd_q   <= ddcp_pkg::RstDirKd;
      speed_kp_q <= ddcp_pkg::RstSpeedKp;
      speed_ki_q <= ddcp_pkg::RstSpeedKi;
      base_q     <= ddcp_pkg::RstBase;
      min_r_q    <= ddcp_pkg::RstMinR;
      min_l_q    <= ddcp_pkg::RstMinL;
      mode_q     <= ddcp_pkg::RstMode;
    end else if (wr_en) begin
      case (reg_idx)
        ddcp_pkg::REG_DIR_KP:   dir_kp_q   <= pwdata[ddcp_pkg::GainW-1:0];
        ddcp_pkg::REG_DIR_KD:   dir_kd_q   <= pwdata[ddcp_pkg::GainW-1:0];
        ddcp_pkg::REG_SPEED_KP: speed_kp_q <= pwdata[ddcp_pkg::GainW-1:0];
        ddcp_pkg::REG_SPEED_KI: speed_ki_q <= pwdata[ddcp_pkg::GainW-1:0];
        ddcp_pkg::REG_BASE:     base_q     <= pwdata[ddcp_pkg::BaseW-1:0];
        ddcp_pkg::REG_MIN_R:    min_r_q    <= pwdata[ddcp_pkg::PwmW-1:0];
        ddcp_pkg::REG_MIN_L:    min_l_q    <= pwdata[ddcp_pkg::PwmW-1:0];
        ddcp_pkg::REG_MODE:     mode_q     <= pwdata[ddcp_pkg::ModeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ddcp_pkg::REG_DIR_KP:   prdata = ddcp_pkg::DataW'(dir_kp_q);
      ddcp_pkg::REG_DIR_KD:   prdata = ddcp_pkg::DataW'(dir_kd_q);
      ddcp_pkg::REG_SPEED_KP: prdata = ddcp_pkg::DataW'(speed_kp_q);
      ddcp_pkg::REG_SPEED_KI: prdata = ddcp_pkg::DataW'(speed_ki_q);
      ddcp_pkg::REG_BASE:     prdata = ddcp_pkg::DataW'(base_q);
      ddcp_pkg::REG_MIN_R:    prdata = ddcp_pkg::DataW'(min_r_q);
      ddcp_pkg::REG_MIN_L:    prdata = ddcp_pkg::DataW'(min_l_q);
      ddcp_pkg::REG_MODE:     prdata = ddcp_pkg::DataW'(mode_q);
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- input side
  assign in_if.ready = (state_q == ddcp_pkg::ST_IDLE);
  assign in_accept   = in_if.valid && in_if.ready;

  // encoders are held for the lanes; the direction unit samples the error itself
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      enc_r_q <= in_if.encoder_right;
      enc_l_q <= in_if.encoder_left;
    end
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    dir_cfg.kp     = dir_kp_q;
    dir_cfg.kd     = dir_kd_q;
    dir_cfg.square = mode_q[ddcp_pkg::ModeSquareBit];

    cfg_r.kp         = speed_kp_q;
    cfg_r.ki         = speed_ki_q;
    cfg_r.base_speed = base_q;
    cfg_r.pwm_min    = min_r_q;
    cfg_r.cumulative = mode_q[ddcp_pkg::ModeCumulBit];

    cfg_l         = cfg_r;
    cfg_l.pwm_min = min_l_q;
  end

  ddcp_dir u_dir (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (in_accept),
    .line_error_i (in_if.line_error),
    .cfg_i        (dir_cfg),
    .done_o       (dir_done),
    .offset_o     (offset)
  );

  // right wheel steers against the offset, left wheel with it
  ddcp_lane u_lane_r (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dir_done),
    .subtract_i (1'b1),
    .offset_i   (offset),
    .encoder_i  (enc_r_q),
    .cfg_i      (cfg_r),
    .done_o     (done_r),
    .pwm_o      (pwm_r)
  );

  ddcp_lane u_lane_l (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dir_done),
    .subtract_i (1'b0),
    .offset_i   (offset),
    .encoder_i  (enc_l_q),
    .cfg_i      (cfg_l),
    .done_o     (done_l),
    .pwm_o      (pwm_l)
  );

  // ---------------------------------------------------------------- sequencer
  assign out_free = !out_valid_q || out_if.ready;

  always_comb begin
    state_d = state_q;
    load    = 1'b0;
    case (state_q)
      ddcp_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = ddcp_pkg::ST_RUN;
        end
      end
      ddcp_pkg::ST_RUN: begin
        if (done_r && done_l) begin
          if (out_free) begin
            load    = 1'b1;
            state_d = ddcp_pkg::ST_IDLE;
          end else begin
            state_d = ddcp_pkg::ST_HOLD;
          end
        end
      end
      ddcp_pkg::ST_HOLD: begin
        // lanes keep their result until the register drains
        if (out_free) begin
          load    = 1'b1;
          state_d = ddcp_pkg::ST_IDLE;
        end
      end
      default: state_d = ddcp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ddcp_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // merge both lanes into one result beat
  always_ff @(posedge clk_i) begin
    if (load) begin
      pwm_r_q <= pwm_r;
      pwm_l_q <= pwm_l;
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.pwm_right = pwm_r_q;
  assign out_if.pwm_left  = pwm_l_q;

endmodule

FILE: hdl/ddcp_checker.sv
// Port-level checks of the cascaded PID block, bound to the top level.
module ddcp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [ddcp_pkg::PwmW-1:0]   pwm_right_i,
  input logic [ddcp_pkg::PwmW-1:0]   pwm_left_i
);

  // one tick in flight: no beat straight after an accepted one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input accepted back to back");

  a_pwm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pwm_right_i <= ddcp_pkg::PwmMax) && (pwm_left_i <= ddcp_pkg::PwmMax))
    else $error("pwm above full scale");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result offered during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> ($stable(pwm_right_i) && $stable(pwm_left_i)))
    else $error("result changed while stalled");

endmodule

bind differential_drive_cascaded_pid ddcp_checker u_ddcp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .pwm_right_i (out_if.pwm_right),
  .pwm_left_i  (out_if.pwm_left)
);

FILE: tb/tb_differential_drive_cascaded_pid.sv
// Self-checking testbench of the cascaded PID wheel controller: stimulus, prediction, checks.
`timescale 1ns / 1ps

module tb_differential_drive_cascaded_pid;
  import ddcp_pkg::*;

  // Arithmetic bounds used by the predictor, all held as 64-bit signed values.
  localparam longint QOne    = 64'sd1 << FracBits;
  localparam longint PwmTop  = 64'sd7100;
  localparam longint I16Min  = -64'sd32768;
  localparam longint I16Max  = 64'sd32767;
  localparam longint I32Min  = -64'sd2147483648;
  localparam longint I32Max  = 64'sd2147483647;

  localparam int unsigned DrainCycles = 20;
  localparam int unsigned PhaseTicks  = 45;
  localparam int unsigned WindupTicks = 20;          // integrals climb at full error
  localparam logic [7:0]  AllRegs     = 8'hFF;

  typedef struct packed {
    logic [PwmW-1:0] right;
    logic [PwmW-1:0] left;
  } pwm_pair_t;

  // Scoreboard: keeps its own copy of the registers and loop state, predicts the
  // PWM pair of every accepted tick and checks result beats in order.
  class drive_scoreboard;
    longint dir_kp, dir_kd, speed_kp, speed_ki, base_speed, min_r, min_l;
    logic [ModeW-1:0] mode;
    longint prev_err, tgt_r, tgt_l, integ_r, integ_l, acc_r, acc_l;
    pwm_pair_t pwm_due_q[$];
    int unsigned faults;

    function new();
      dir_kp     = RstDirKp;
      dir_kd     = RstDirKd;
      speed_kp   = RstSpeedKp;
      speed_ki   = RstSpeedKi;
      base_speed = RstBase;
      min_r      = RstMinR;
      min_l      = RstMinL;
      mode       = RstMode;
      prev_err   = 0;
      tgt_r      = RstBase;
      tgt_l      = RstBase;
      integ_r    = 0;
      integ_l    = 0;
      acc_r      = 0;
      acc_l      = 0;
      faults     = 0;
    endfunction

    function longint clamp_to(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function void write_reg(reg_idx_e idx, logic [DataW-1:0] value);
      case (idx)
        REG_DIR_KP:   dir_kp = value[GainW-1:0];
        REG_DIR_KD:   dir_kd = value[GainW-1:0];
        REG_SPEED_KP: speed_kp = value[GainW-1:0];
        REG_SPEED_KI: speed_ki = value[GainW-1:0];
        REG_BASE:     base_speed = value[BaseW-1:0];
        REG_MIN_R:    min_r = value[PwmW-1:0];
        REG_MIN_L:    min_l = value[PwmW-1:0];
        REG_MODE:     mode = value[ModeW-1:0];
        default: ;
      endcase
    endfunction

    // One wheel: PI on the speed error, integral and accumulator saturate,
    // then the accumulator is raised to the minimum and limited to 7100.
    function logic [PwmW-1:0] wheel_step(input longint target, input longint enc,
                                         inout longint integ, inout longint acc,
                                         input longint pmin);
      longint err, pi, lo, v;
      err   = target - enc;
      lo    = (pmin > PwmTop) ? PwmTop : pmin;
      integ = clamp_to(integ + err, I32Min, I32Max);
      pi    = (speed_kp * err + speed_ki * integ) / QOne;
      acc   = clamp_to(acc + pi, I16Min, I16Max);
      v     = (acc < lo) ? lo : acc;
      if (v > PwmTop) v = PwmTop;
      return v[PwmW-1:0];
    endfunction

    function void note_tick(logic signed [ErrW-1:0] line_err,
                            logic signed [EncW-1:0] enc_r,
                            logic signed [EncW-1:0] enc_l);
      longint e, term, offset;
      pwm_pair_t due;
      e = line_err;
      if (mode[ModeSquareBit]) term = (e < 0) ? -(e * e) : e * e;
      else term = e;
      offset   = (dir_kp * term + dir_kd * (e - prev_err)) / QOne;
      prev_err = e;
      if (mode[ModeCumulBit]) begin
        tgt_r = clamp_to(tgt_r - offset, I16Min, I16Max);
        tgt_l = clamp_to(tgt_l + offset, I16Min, I16Max);
      end else begin
        tgt_r = clamp_to(base_speed - offset, I16Min, I16Max);
        tgt_l = clamp_to(base_speed + offset, I16Min, I16Max);
      end
      due.right = wheel_step(tgt_r, longint'(enc_r), integ_r, acc_r, min_r);
      due.left  = wheel_step(tgt_l, longint'(enc_l), integ_l, acc_l, min_l);
      pwm_due_q.push_back(due);
    endfunction

    function void check_pwm(logic [PwmW-1:0] pwm_r, logic [PwmW-1:0] pwm_l);
      pwm_pair_t due;
      if (pwm_due_q.size() == 0) begin
        $display("%0t: unexpected result beat, pwm_right %0d pwm_left %0d",
                 $time, pwm_r, pwm_l);
        faults++;
        return;
      end
      due = pwm_due_q.pop_front();
      if (pwm_r !== due.right) begin
        $display("%0t: pwm_right expected %0d got %0d", $time, due.right, pwm_r);
        faults++;
      end
      if (pwm_l !== due.left) begin
        $display("%0t: pwm_left expected %0d got %0d", $time, due.left, pwm_l);
        faults++;
      end
    endfunction

    function int unsigned pending();
      return pwm_due_q.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel, penable, pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata, prdata;
  logic              pready;

  ddcp_in_if  tick_if ();
  ddcp_out_if pwm_if ();

  differential_drive_cascaded_pid dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_if   (tick_if),
    .out_if  (pwm_if)
  );

  drive_scoreboard sb = new();

  logic [DataW-1:0] cfg_vals [8];   // register image that program_regs writes to the block
  bit               src_steady;     // sender offers back to back
  bit               sink_steady;    // receiver adds no random stalls
  int unsigned      sink_hold;      // long hold-off, counted down by the receiver

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idle stretch, drawn from a short range eight times in ten and from a long range otherwise.
  function automatic int unsigned idle_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // Monitor: both channels sampled at the edge; an accepted tick is predicted
  // before a result beat of the same edge is checked, the latter always being older.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (tick_if.valid && tick_if.ready)
        sb.note_tick(tick_if.line_error, tick_if.encoder_right, tick_if.encoder_left);
      if (pwm_if.valid && pwm_if.ready)
        sb.check_pwm(pwm_if.pwm_right, pwm_if.pwm_left);
    end
  end

  // Receiver: random stalls, a long hold-off on request, or none at all.
  initial begin : pwm_sink
    int unsigned stall;
    stall = 0;
    sink_hold = 0;
    sink_steady = 1'b0;
    pwm_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold > 0) begin
        pwm_if.ready <= 1'b0;
        sink_hold--;
      end else if (stall > 0) begin
        pwm_if.ready <= 1'b0;
        stall--;
      end else if (!sink_steady && $urandom_range(0, 3) == 0) begin
        pwm_if.ready <= 1'b0;
        stall = idle_len() - 1;
      end else begin
        pwm_if.ready <= 1'b1;
      end
    end
  end

  // Offer one tick beat; valid stays high into the next call unless it idles first.
  task automatic send_tick(input logic signed [ErrW-1:0] line_err,
                           input logic signed [EncW-1:0] enc_r,
                           input logic signed [EncW-1:0] enc_l);
    int unsigned gap;
    gap = (!src_steady && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      tick_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tick_if.valid         <= 1'b1;
    tick_if.line_error    <= line_err;
    tick_if.encoder_right <= enc_r;
    tick_if.encoder_left  <= enc_l;
    do @(posedge clk_i); while (!tick_if.ready);
  endtask

  // Encoder count close to the wheel's present target, so the loop behaves.
  function automatic logic signed [EncW-1:0] near_count(longint target);
    longint v;
    v = target + longint'($urandom_range(0, 40)) - 20;
    if (v > I16Max) v = I16Max;
    if (v < I16Min) v = I16Min;
    return v[EncW-1:0];
  endfunction

  // Mostly plausible ticks (small line error, counts near target), some raw noise.
  task automatic send_random();
    logic signed [ErrW-1:0] line_err;
    logic signed [EncW-1:0] enc_r, enc_l;
    if ($urandom_range(0, 9) == 0) begin
      line_err = ErrW'($urandom);
      enc_r    = EncW'($urandom);
      enc_l    = EncW'($urandom);
    end else begin
      line_err = sb.mode[ModeSquareBit] ? ErrW'($urandom_range(0, 96) - 48)
                                        : ErrW'($urandom_range(0, 600) - 300);
      enc_r = near_count(sb.tgt_r);
      enc_l = near_count(sb.tgt_l);
    end
    send_tick(line_err, enc_r, enc_l);
  endtask

  // APB writes of the selected registers, back to back; psel drops after the last.
  task automatic program_regs(input logic [7:0] which);
    int i;
    for (i = 0; i < 8; i++) begin
      if (which[i]) begin
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'({i[2:0], 2'b00});
        pwdata  <= cfg_vals[i];
        @(posedge clk_i);
        penable <= 1'b1;
        do @(posedge clk_i); while (!pready);
        sb.write_reg(reg_idx_e'(i), cfg_vals[i]);
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Sender goes quiet until every predicted beat is back, then waits out a further drain margin.
  task automatic settle();
    tick_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Register value with random junk above the field now and then.
  function automatic logic [DataW-1:0] with_junk(int unsigned v, int unsigned w);
    return ($urandom_range(0, 3) == 0) ? (v | ($urandom << w)) : v;
  endfunction

  function automatic int unsigned pick_gain(int unsigned typical);
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(0, typical);
    endcase
  endfunction

  // Minimum clamp: zero, the ceiling, beyond the ceiling, or a working value.
  function automatic int unsigned pick_min();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 7100;
      2: return $urandom_range(7101, 8191);
      default: return $urandom_range(0, 3000);
    endcase
  endfunction

  task automatic roll_config();
    int unsigned base;
    case ($urandom_range(0, 5))
      0: base = 0;
      1: base = 1023;
      default: base = $urandom_range(0, 300);
    endcase
    cfg_vals[REG_DIR_KP]   = with_junk(pick_gain(3000), GainW);
    cfg_vals[REG_DIR_KD]   = with_junk(pick_gain(6000), GainW);
    cfg_vals[REG_SPEED_KP] = with_junk(pick_gain(40000), GainW);
    cfg_vals[REG_SPEED_KI] = with_junk(pick_gain(3000), GainW);
    cfg_vals[REG_BASE]     = with_junk(base, BaseW);
    cfg_vals[REG_MIN_R]    = with_junk(pick_min(), PwmW);
    cfg_vals[REG_MIN_L]    = with_junk(pick_min(), PwmW);
    cfg_vals[REG_MODE]     = with_junk($urandom_range(0, 3), ModeW);
  endtask

  initial begin : stimulus
    int phase, n;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    tick_if.valid         <= 1'b0;
    tick_if.line_error    <= '0;
    tick_if.encoder_right <= '0;
    tick_if.encoder_left  <= '0;
    src_steady = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset gains: zero tick, field extremes and a full-swing derivative step.
    send_tick(0, 0, 0);
    send_tick(12'sh7ff, 16'sh7fff, 16'sh8000);
    send_tick(12'sh800, 16'sh8000, 16'sh7fff);
    send_tick(12'sh800, 120, 120);
    send_tick(0, 120, 120);
    send_tick(5, 118, 121);
    settle();

    // Every gain at full scale, squared and cumulative: targets, accumulators
    // saturate; right minimum above the ceiling behaves as 7100.
    cfg_vals[REG_DIR_KP]   = 32'hffff;
    cfg_vals[REG_DIR_KD]   = 32'hffff;
    cfg_vals[REG_SPEED_KP] = 32'hffff;
    cfg_vals[REG_SPEED_KI] = 32'hffff;
    cfg_vals[REG_BASE]     = 32'd1023;
    cfg_vals[REG_MIN_R]    = 32'd8191;
    cfg_vals[REG_MIN_L]    = 32'd0;
    cfg_vals[REG_MODE]     = 32'd3;
    program_regs(AllRegs);
    send_tick(12'sh7ff, 0, 0);
    send_tick(12'sh7ff, 0, 0);
    send_tick(12'sh800, 16'sh7fff, 16'sh8000);
    send_tick(-1, -1, -1);
    send_tick(0, 0, 0);
    settle();

    // Unity proportional gains, zero derivative and integral gains, cumulative targets that ignore the new base speed.
    cfg_vals[REG_DIR_KP]   = 32'd4096;
    cfg_vals[REG_DIR_KD]   = 32'd0;
    cfg_vals[REG_SPEED_KP] = 32'd4096;
    cfg_vals[REG_SPEED_KI] = 32'd0;
    cfg_vals[REG_BASE]     = 32'd500;
    cfg_vals[REG_MIN_R]    = 32'd0;
    cfg_vals[REG_MIN_L]    = 32'd7100;
    cfg_vals[REG_MODE]     = 32'd2;
    program_regs(AllRegs);
    send_tick(10, 0, 0);
    send_tick(10, 0, 0);
    send_tick(-3, 0, 0);
    settle();

    // Back to plain targets: the base speed written earlier only now applies.
    cfg_vals[REG_MODE] = 32'd0;
    program_regs(8'h80);
    send_tick(0, 500, 500);
    send_tick(1, 0, 0);
    settle();

    // Zero speed gain: accumulator frozen, result decided by the clamps alone.
    cfg_vals[REG_BASE]     = 32'd0;
    cfg_vals[REG_SPEED_KP] = 32'd0;
    program_regs(8'h14);
    send_tick(7, 16'sh8000, 16'sh7fff);
    settle();

    // Random phases, each with fresh registers. Phase 2 runs flat out, phase 4
    // holds the receiver off long enough to back the block up, phase 5 lets the
    // block drain completely midway.
    for (phase = 0; phase < 8; phase++) begin
      roll_config();
      program_regs(AllRegs);
      src_steady  = (phase == 2);
      sink_steady = (phase == 2);
      for (n = 0; n < PhaseTicks; n++) begin
        if (phase == 4 && n == 10) sink_hold = 300;
        if (phase == 5 && n == 25) settle();
        send_random();
      end
      settle();
    end

    // Wind-up: targets pinned at opposite rails so each integral moves by
    // 65535 a tick, towards its 32-bit limit.
    cfg_vals[REG_DIR_KP]   = 32'hffff;
    cfg_vals[REG_DIR_KD]   = 32'd0;
    cfg_vals[REG_SPEED_KP] = 32'd0;
    cfg_vals[REG_SPEED_KI] = 32'd1;
    cfg_vals[REG_MIN_R]    = 32'd0;
    cfg_vals[REG_MIN_L]    = 32'd0;
    cfg_vals[REG_MODE]     = 32'd3;
    program_regs(AllRegs);
    src_steady  = 1'b1;
    sink_steady = 1'b1;
    for (n = 0; n < WindupTicks; n++)
      send_tick(12'sh800, 16'sh8000, 16'sh7fff);
    settle();

    if (sb.faults == 0 && sb.pending() == 0) begin
      $display("PASS differential_drive_cascaded_pid");
    end else begin
      $display("FAIL differential_drive_cascaded_pid");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run (about 0.5 ms with every
  // gap and stall at its longest).
  initial begin : watchdog
    #2_000_000;
    $display("FAIL differential_drive_cascaded_pid");
    $finish;
  end

endmodule
